// ===== hw/rtl/dcc_pkg.sv =====
// dcc_pkg: shared types, register codes and the servo count table of the
// drive command conditioner. No dependencies; used by every dcc_* module
// and by the top level.
package dcc_pkg;

    // servo pulse timing
    localparam int PULSE_MIN_US   = 600;
    localparam int PULSE_MAX_US   = 2400;
    localparam int SERVO_FRAME_HZ = 60;

    // throttle limits in q1.15
    localparam logic [14:0] THROTTLE_MAX = 15'd32767;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_LIN_FULL_SCALE = 3'd0,
        REG_ANG_FULL_SCALE = 3'd1,
        REG_DEADBAND       = 3'd2,
        REG_ACCEL_STEP     = 3'd3,
        REG_TIMEOUT_TICKS  = 3'd4,
        REG_CENTER_ANGLE   = 3'd5,
        REG_MIN_ANGLE      = 3'd6,
        REG_MAX_ANGLE      = 3'd7
    } cfg_idx_t;

    // item kinds
    typedef enum logic {
        OP_COMMAND = 1'b0,
        OP_TICK    = 1'b1
    } op_t;

    // configuration register file
    typedef struct packed {
        logic [14:0] lin_full_scale;
        logic [14:0] ang_full_scale;
        logic [14:0] deadband;
        logic [14:0] accel_step;
        logic [7:0]  timeout_ticks;
        logic [7:0]  center_angle;
        logic [7:0]  min_angle;
        logic [7:0]  max_angle;
    } cfg_t;

    // tick job: target snapshot after the timeout check
    typedef struct packed {
        logic signed [15:0] lin;
        logic signed [15:0] ang;
    } job_t;

    // servo off count for each angle in degrees
    typedef logic [11:0] servo_lut_t [256];

    function automatic servo_lut_t servo_lut_f();
        servo_lut_t lut;
        longint     num;
        longint     den;
        longint     den2;
        longint     acc;
        longint     r;
        den  = longint'(180) * longint'(1000000);
        den2 = 2 * den;
        for (int i = 0; i < 256; i++)
        begin
            num = longint'(PULSE_MIN_US) * 180 + longint'(PULSE_MAX_US - PULSE_MIN_US) * i;
            if (num <= 0)
            begin
                r = 0;
            end
            else
            begin
                num = num * 4096 * SERVO_FRAME_HZ;
                // rounded quotient by restoring steps, quotient stays below 2^13
                acc = 2 * num + den;
                r   = 0;
                for (int b = 12; b >= 0; b--)
                begin
                    if (acc >= (den2 <<< b))
                    begin
                        acc = acc - (den2 <<< b);
                        r   = r + (longint'(1) <<< b);
                    end
                end
                if (r > 4095)
                    r = 4095;
            end
            lut[i] = 12'(r);
        end
        return lut;
    endfunction

    localparam servo_lut_t SERVO_LUT = servo_lut_f();

endpackage

// ===== hw/rtl/dcc_front.sv =====
// dcc_front: takes items, keeps the targets and the command timeout,
// and queues one job per tick. Depends on dcc_pkg.
module dcc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                operation,
    input  logic signed [15:0]  linear_cmd,
    input  logic signed [15:0]  angular_cmd,
    input  logic [7:0]          timeout_ticks,
    input  logic                job_full,
    output logic                job_wr,
    output dcc_pkg::job_t       job_data
);

    logic signed [15:0] tgt_lin_reg, tgt_lin_next;
    logic signed [15:0] tgt_ang_reg, tgt_ang_next;
    logic [7:0]         ticks_reg, ticks_next;
    logic               accept;
    logic [7:0]         ticks_inc;
    logic               timed_out;

    assign full   = job_full;
    assign accept = push && !job_full;

    // saturating tick count and timeout test
    assign ticks_inc = (ticks_reg == 8'hFF) ? 8'hFF : ticks_reg + 8'd1;
    assign timed_out = ticks_inc > timeout_ticks;

    // classify the item and update targets
    always_comb
    begin
        tgt_lin_next = tgt_lin_reg;
        tgt_ang_next = tgt_ang_reg;
        ticks_next   = ticks_reg;
        job_wr       = 1'b0;
        job_data.lin = tgt_lin_reg;
        job_data.ang = tgt_ang_reg;
        if (accept)
        begin
            case (dcc_pkg::op_t'(operation))
                dcc_pkg::OP_COMMAND:
                begin
                    tgt_lin_next = linear_cmd;
                    tgt_ang_next = angular_cmd;
                    ticks_next   = 8'd0;
                end
                dcc_pkg::OP_TICK:
                begin
                    ticks_next = ticks_inc;
                    job_wr     = 1'b1;
                    if (timed_out)
                    begin
                        tgt_lin_next = 16'sd0;
                        tgt_ang_next = 16'sd0;
                    end
                    job_data.lin = tgt_lin_next;
                    job_data.ang = tgt_ang_next;
                end
                default:
                begin
                    ticks_next = ticks_reg;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_lin_reg <= 16'sd0;
            tgt_ang_reg <= 16'sd0;
            ticks_reg   <= 8'hFF;
        end
        else
        begin
            tgt_lin_reg <= tgt_lin_next;
            tgt_ang_reg <= tgt_ang_next;
            ticks_reg   <= ticks_next;
        end
    end

endmodule

// ===== hw/rtl/dcc_job_queue.sv =====
// dcc_job_queue: short first-in first-out queue of tick jobs between the
// front and the back. Depends on dcc_pkg.
module dcc_job_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  dcc_pkg::job_t wr_data,
    output logic          full,
    input  logic          rd,
    output dcc_pkg::job_t rd_data,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dcc_pkg::job_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== hw/rtl/dcc_back.sv =====
// dcc_back: sequencer that turns one tick job into a result item: throttle
// divide, deadband, slew limit, steering divide and servo table lookup.
// Depends on dcc_pkg.
module dcc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  dcc_pkg::cfg_t       cfg,
    input  dcc_pkg::job_t       job_data,
    input  logic                job_empty,
    output logic                job_rd,
    output logic                empty,
    input  logic                pop,
    output logic [11:0]         motor_duty,
    output logic                dir_forward,
    output logic                dir_reverse,
    output logic [11:0]         servo_count,
    output logic signed [15:0]  throttle_now
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_DIV  = 6'b000100,
        S_GOAL = 6'b001000,
        S_SLEW = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic               lin_neg_reg, lin_neg_next;
    logic [15:0]        lin_mag_reg, lin_mag_next;
    logic [14:0]        ang_a_reg, ang_a_next;
    logic [8:0]         span_reg, span_next;
    logic               flip_reg, flip_next;
    logic               steer_on_reg, steer_on_next;
    logic [15:0]        trem_reg, trem_next;
    logic [14:0]        tquo_reg, tquo_next;
    logic [23:0]        srem_reg, srem_next;
    logic [7:0]         soff_reg, soff_next;
    logic signed [15:0] goal_reg, goal_next;
    logic signed [9:0]  deg_raw_reg, deg_raw_next;
    logic [7:0]         deg_reg, deg_next;
    logic signed [15:0] cur_reg, cur_next;
    logic               res_valid_reg, res_valid_next;
    logic [11:0]        res_duty_reg, res_servo_reg;
    logic               res_fwd_reg, res_rev_reg;
    logic signed [15:0] res_thr_reg;
    logic               res_wr;

    // job setup terms
    logic               ang_neg;
    logic [15:0]        ang_mag;
    logic signed [9:0]  c10, lo10, hi10, span10;
    logic               span_neg;
    logic [23:0]        prod;

    // divider step terms
    logic [16:0]        t2;
    logic               tge;
    logic [2:0]         sk;
    logic [23:0]        sdiv;
    logic               sge;

    // goal and slew terms
    logic [14:0]        qsat;
    logic [14:0]        qdb;
    logic signed [16:0] diff;
    logic signed [16:0] step17;
    logic signed [9:0]  deg_lo;

    // result terms
    logic [14:0]        cur_mag;
    logic [27:0]        duty_full;

    // steering set-up from the queue head
    assign ang_neg  = job_data.ang[15];
    assign ang_mag  = ang_neg ? 16'(-job_data.ang) : 16'(job_data.ang);
    assign c10      = signed'({2'b00, cfg.center_angle});
    assign lo10     = signed'({2'b00, cfg.min_angle});
    assign hi10     = signed'({2'b00, cfg.max_angle});
    assign span10   = ang_neg ? c10 - lo10 : hi10 - c10;
    assign span_neg = span10[9];
    assign prod     = 24'(ang_a_reg) * 24'(span_reg);

    // one restoring step for each divider
    assign t2   = {trem_reg, 1'b0};
    assign tge  = t2 >= {2'b00, cfg.lin_full_scale};
    assign sk   = 3'(cnt_reg - 4'd7);
    assign sdiv = 24'({cfg.ang_full_scale, 1'b0}) << sk;
    assign sge  = srem_reg >= sdiv;

    // throttle goal after saturation and deadband
    assign qsat = (cfg.lin_full_scale == 15'd0) ? 15'd0 :
                  (lin_mag_reg >= {1'b0, cfg.lin_full_scale}) ? dcc_pkg::THROTTLE_MAX :
                  tquo_reg;
    assign qdb  = (qsat < cfg.deadband) ? 15'd0 : qsat;

    // slew limit
    assign step17 = signed'({2'b00, cfg.accel_step});
    assign diff   = 17'(goal_reg) - 17'(cur_reg);
    assign deg_lo = (deg_raw_reg < lo10) ? lo10 : deg_raw_reg;

    // duty from the ramped throttle
    assign cur_mag   = cur_reg[15] ? 15'(-cur_reg) : 15'(cur_reg);
    assign duty_full = 28'(cur_mag) * 28'd4095 + 28'd16384;

    assign res_wr = (state_reg == S_DONE) && (!res_valid_reg || pop);
    assign job_rd = (state_reg == S_IDLE) && !job_empty;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        lin_neg_next  = lin_neg_reg;
        lin_mag_next  = lin_mag_reg;
        ang_a_next    = ang_a_reg;
        span_next     = span_reg;
        flip_next     = flip_reg;
        steer_on_next = steer_on_reg;
        trem_next     = trem_reg;
        tquo_next     = tquo_reg;
        srem_next     = srem_reg;
        soff_next     = soff_reg;
        goal_next     = goal_reg;
        deg_raw_next  = deg_raw_reg;
        deg_next      = deg_reg;
        cur_next      = cur_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!job_empty)
                begin
                    lin_neg_next  = job_data.lin[15];
                    lin_mag_next  = job_data.lin[15] ? 16'(-job_data.lin) : 16'(job_data.lin);
                    ang_a_next    = (ang_mag > {1'b0, cfg.ang_full_scale}) ?
                                    cfg.ang_full_scale : ang_mag[14:0];
                    span_next     = span_neg ? 9'(-span10) : 9'(span10);
                    flip_next     = ang_neg != span_neg;
                    steer_on_next = (cfg.ang_full_scale != 15'd0) && (job_data.ang != 16'sd0);
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                srem_next  = {prod[22:0], 1'b0} + 24'(cfg.ang_full_scale);
                soff_next  = 8'd0;
                trem_next  = lin_mag_reg;
                tquo_next  = 15'd0;
                cnt_next   = 4'd14;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                trem_next = tge ? 16'(t2 - {2'b00, cfg.lin_full_scale}) : t2[15:0];
                tquo_next = {tquo_reg[13:0], tge};
                if (cnt_reg >= 4'd7)
                begin
                    srem_next = sge ? srem_reg - sdiv : srem_reg;
                    soff_next = {soff_reg[6:0], sge};
                end
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                    state_next = S_GOAL;
            end
            S_GOAL:
            begin
                goal_next = lin_neg_reg ? -signed'({1'b0, qdb}) : signed'({1'b0, qdb});
                if (!steer_on_reg)
                    deg_raw_next = c10;
                else if (flip_reg)
                    deg_raw_next = c10 - signed'({2'b00, soff_reg});
                else
                    deg_raw_next = c10 + signed'({2'b00, soff_reg});
                state_next = S_SLEW;
            end
            S_SLEW:
            begin
                if (diff > step17)
                    cur_next = 16'(17'(cur_reg) + step17);
                else if (diff < -step17)
                    cur_next = 16'(17'(cur_reg) - step17);
                else
                    cur_next = goal_reg;
                deg_next   = (deg_lo > hi10) ? cfg.max_angle : deg_lo[7:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_wr)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result slot
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_wr)
            res_valid_next = 1'b1;
        else if (pop)
            res_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 4'd0;
            cur_reg       <= 16'sd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cur_reg       <= cur_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        lin_neg_reg  <= lin_neg_next;
        lin_mag_reg  <= lin_mag_next;
        ang_a_reg    <= ang_a_next;
        span_reg     <= span_next;
        flip_reg     <= flip_next;
        steer_on_reg <= steer_on_next;
        trem_reg     <= trem_next;
        tquo_reg     <= tquo_next;
        srem_reg     <= srem_next;
        soff_reg     <= soff_next;
        goal_reg     <= goal_next;
        deg_raw_reg  <= deg_raw_next;
        deg_reg      <= deg_next;
        if (res_wr)
        begin
            res_duty_reg  <= duty_full[26:15];
            res_fwd_reg   <= !cur_reg[15] && (cur_reg != 16'sd0);
            res_rev_reg   <= cur_reg[15];
            res_servo_reg <= dcc_pkg::SERVO_LUT[deg_reg];
            res_thr_reg   <= cur_reg;
        end
    end

    assign empty        = !res_valid_reg;
    assign motor_duty   = res_duty_reg;
    assign dir_forward  = res_fwd_reg;
    assign dir_reverse  = res_rev_reg;
    assign servo_count  = res_servo_reg;
    assign throttle_now = res_thr_reg;

endmodule

// ===== hw/rtl/drive_command_conditioner.sv =====
// drive_command_conditioner: top level with the configuration registers,
// front, job queue and back. Depends on dcc_pkg, dcc_front, dcc_job_queue, dcc_back.
//
// input channel: push/full with operation, linear_cmd, angular_cmd. an item is
//   taken at a clock edge with push high and full low. a command item updates the
//   targets and restarts the timeout in the cycle it is taken and gives no result.
//   a tick item is queued (QUEUE_DEPTH entries) with its target snapshot.
// result channel: empty/pop. while empty is low the oldest result is on
//   motor_duty, dir_forward, dir_reverse, servo_count, throttle_now and is taken
//   at an edge with pop high. one result per tick.
// sequence: the back works on one tick at a time through setup, one multiply,
//   15 steps of the throttle divider (the steering divider steps in the earlier
//   ones), goal, slew and write-out, and takes the next job only when idle.
// stalls: a result waiting for pop holds the back in its write-out step; the
//   job queue keeps taking items until it fills, then full rises.
// reset: rst_n clears the queue and the result slot, zeroes targets and throttle,
//   marks the command timeout as already expired unless timeout_ticks is 255 and
//   loads the default configuration. configuration is written by the user through
//   cfg_wr_en, cfg_index and cfg_data only while the block is idle; the block does not enforce it.
module drive_command_conditioner #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [14:0]         cfg_data,
    input  logic                push,
    output logic                full,
    input  logic                operation,
    input  logic signed [15:0]  linear_cmd,
    input  logic signed [15:0]  angular_cmd,
    output logic                empty,
    input  logic                pop,
    output logic [11:0]         motor_duty,
    output logic                dir_forward,
    output logic                dir_reverse,
    output logic [11:0]         servo_count,
    output logic signed [15:0]  throttle_now
);

    dcc_pkg::cfg_t cfg_reg, cfg_next;
    dcc_pkg::job_t job_wr_data;
    dcc_pkg::job_t job_rd_data;
    logic          job_wr;
    logic          job_rd;
    logic          job_full;
    logic          job_empty;

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (dcc_pkg::cfg_idx_t'(cfg_index))
                dcc_pkg::REG_LIN_FULL_SCALE: cfg_next.lin_full_scale = cfg_data;
                dcc_pkg::REG_ANG_FULL_SCALE: cfg_next.ang_full_scale = cfg_data;
                dcc_pkg::REG_DEADBAND:       cfg_next.deadband       = cfg_data;
                dcc_pkg::REG_ACCEL_STEP:     cfg_next.accel_step     = cfg_data;
                dcc_pkg::REG_TIMEOUT_TICKS:  cfg_next.timeout_ticks  = cfg_data[7:0];
                dcc_pkg::REG_CENTER_ANGLE:   cfg_next.center_angle   = cfg_data[7:0];
                dcc_pkg::REG_MIN_ANGLE:      cfg_next.min_angle      = cfg_data[7:0];
                dcc_pkg::REG_MAX_ANGLE:      cfg_next.max_angle      = cfg_data[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lin_full_scale <= 15'd500;
            cfg_reg.ang_full_scale <= 15'd1000;
            cfg_reg.deadband       <= 15'd983;
            cfg_reg.accel_step     <= 15'd983;
            cfg_reg.timeout_ticks  <= 8'd15;
            cfg_reg.center_angle   <= 8'd100;
            cfg_reg.min_angle      <= 8'd50;
            cfg_reg.max_angle      <= 8'd140;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: item intake and targets
    dcc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .linear_cmd    (linear_cmd),
        .angular_cmd   (angular_cmd),
        .timeout_ticks (cfg_reg.timeout_ticks),
        .job_full      (job_full),
        .job_wr        (job_wr),
        .job_data      (job_wr_data)
    );

    // queue of tick jobs
    dcc_job_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (job_wr),
        .wr_data (job_wr_data),
        .full    (job_full),
        .rd      (job_rd),
        .rd_data (job_rd_data),
        .empty   (job_empty)
    );

    // back: arithmetic and result slot
    dcc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .job_data     (job_rd_data),
        .job_empty    (job_empty),
        .job_rd       (job_rd),
        .empty        (empty),
        .pop          (pop),
        .motor_duty   (motor_duty),
        .dir_forward  (dir_forward),
        .dir_reverse  (dir_reverse),
        .servo_count  (servo_count),
        .throttle_now (throttle_now)
    );

endmodule

// ===== test/drive_command_conditioner_tb.sv =====
// drive_command_conditioner_tb: self-checking bench for the drive command conditioner
// a scoreboard class predicts each tick output from the accepted items
// depends on dcc_pkg and drive_command_conditioner
module drive_command_conditioner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 300;
    localparam int ITEMS_PER_PH = 92;
    localparam int SETTLE_WAIT  = 40;

    // one tick output as seen on the result ports
    typedef struct packed {
        logic [11:0]        duty;
        logic               fwd;
        logic               rev;
        logic [11:0]        servo;
        logic signed [15:0] thr;
    } drive_out_t;

    // throttle and steering predictor with its queue of due outputs
    class drive_scoreboard;
        dcc_pkg::cfg_t      regs;
        logic signed [15:0] goal_lin;
        logic signed [15:0] goal_ang;
        logic signed [15:0] throttle;
        logic [7:0]         quiet_ticks;
        drive_out_t         due_outputs[$];
        int                 failures;
        int                 reported;

        function new();
            regs.lin_full_scale = 15'd500;
            regs.ang_full_scale = 15'd1000;
            regs.deadband       = 15'd983;
            regs.accel_step     = 15'd983;
            regs.timeout_ticks  = 8'd15;
            regs.center_angle   = 8'd100;
            regs.min_angle      = 8'd50;
            regs.max_angle      = 8'd140;
            goal_lin    = '0;
            goal_ang    = '0;
            throttle    = '0;
            quiet_ticks = 8'd255;
            failures    = 0;
            reported    = 0;
        endfunction

        function void set_reg(dcc_pkg::cfg_idx_t idx, logic [14:0] v);
            case (idx)
                dcc_pkg::REG_LIN_FULL_SCALE: regs.lin_full_scale = v;
                dcc_pkg::REG_ANG_FULL_SCALE: regs.ang_full_scale = v;
                dcc_pkg::REG_DEADBAND:       regs.deadband       = v;
                dcc_pkg::REG_ACCEL_STEP:     regs.accel_step     = v;
                dcc_pkg::REG_TIMEOUT_TICKS:  regs.timeout_ticks  = v[7:0];
                dcc_pkg::REG_CENTER_ANGLE:   regs.center_angle   = v[7:0];
                dcc_pkg::REG_MIN_ANGLE:      regs.min_angle      = v[7:0];
                dcc_pkg::REG_MAX_ANGLE:      regs.max_angle      = v[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_outputs.size();
        endfunction

        // q1.15 throttle the ramp heads for, after saturation and deadband
        function int throttle_goal();
            int mag;
            int q;
            if (regs.lin_full_scale == 0)
                return 0;
            mag = int'(goal_lin);
            if (mag < 0)
                mag = -mag;
            q = (mag * 32768) / int'(regs.lin_full_scale);
            if (q > 32767)
                q = 32767;
            if (q < int'(regs.deadband))
                q = 0;
            return (goal_lin < 0) ? -q : q;
        endfunction

        // steering angle in degrees around the centre, limited low then high
        function int steer_deg();
            int  c;
            int  lo;
            int  hi;
            int  ma;
            int  deg;
            int  a;
            int  span;
            int  s;
            int  off;
            bit  neg;
            bit  spn;
            c   = int'(regs.center_angle);
            lo  = int'(regs.min_angle);
            hi  = int'(regs.max_angle);
            ma  = int'(regs.ang_full_scale);
            deg = c;
            if (ma != 0 && goal_ang != 0)
            begin
                neg  = goal_ang < 0;
                a    = int'(goal_ang);
                if (neg)
                    a = -a;
                span = neg ? (c - lo) : (hi - c);
                spn  = span < 0;
                s    = spn ? -span : span;
                if (a > ma)
                    a = ma;
                off  = (2 * a * s + ma) / (2 * ma);
                deg  = (neg != spn) ? c - off : c + off;
            end
            if (deg < lo)
                deg = lo;
            if (deg > hi)
                deg = hi;
            return deg;
        endfunction

        // pwm off count of the servo pulse for an angle, rounded half up
        function logic [11:0] servo_of(int deg);
            longint pulse;
            longint den;
            longint r;
            pulse = longint'(dcc_pkg::PULSE_MIN_US) * 180
                  + longint'(dcc_pkg::PULSE_MAX_US - dcc_pkg::PULSE_MIN_US) * deg;
            pulse = pulse * 4096 * dcc_pkg::SERVO_FRAME_HZ;
            den   = longint'(180) * 1000000;
            r     = (2 * pulse + den) / (2 * den);
            if (r > 4095)
                r = 4095;
            return 12'(r);
        endfunction

        // commands update the targets, ticks give one output
        function void note_item(dcc_pkg::op_t op, logic signed [15:0] lin,
                                logic signed [15:0] ang);
            drive_out_t want;
            int         diff;
            int         step;
            int         thr;
            int         mag;
            if (op == dcc_pkg::OP_COMMAND)
            begin
                goal_lin    = lin;
                goal_ang    = ang;
                quiet_ticks = 8'd0;
                return;
            end
            if (quiet_ticks != 8'd255)
                quiet_ticks++;
            if (quiet_ticks > regs.timeout_ticks)
            begin
                goal_lin = '0;
                goal_ang = '0;
            end
            diff = throttle_goal() - int'(throttle);
            step = int'(regs.accel_step);
            if (diff > step)
                diff = step;
            if (diff < -step)
                diff = -step;
            thr      = int'(throttle) + diff;
            throttle = 16'(thr);
            mag      = (thr < 0) ? -thr : thr;
            want.duty  = 12'((4095 * mag + 16384) >> 15);
            want.fwd   = thr > 0;
            want.rev   = thr < 0;
            want.servo = servo_of(steer_deg());
            want.thr   = 16'(thr);
            due_outputs.push_back(want);
        endfunction

        function void check_output(drive_out_t got);
            drive_out_t want;
            if (due_outputs.size() == 0)
            begin
                failures++;
                if (reported < 10)
                    $display("unexpected output: duty %0d fwd %0b rev %0b servo %0d thr %0d",
                             got.duty, got.fwd, got.rev, got.servo, got.thr);
                reported++;
                return;
            end
            want = due_outputs.pop_front();
            if (got !== want)
            begin
                failures++;
                if (reported < 10)
                begin
                    $display("output mismatch at %0t", $realtime);
                    $display("  expected duty %0d fwd %0b rev %0b servo %0d thr %0d",
                             want.duty, want.fwd, want.rev, want.servo, want.thr);
                    $display("  actual   duty %0d fwd %0b rev %0b servo %0d thr %0d",
                             got.duty, got.fwd, got.rev, got.servo, got.thr);
                end
                reported++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [14:0]        cfg_data;
    logic               push;
    logic               full;
    logic               operation;
    logic signed [15:0] linear_cmd;
    logic signed [15:0] angular_cmd;
    logic               empty;
    logic               pop;
    logic [11:0]        motor_duty;
    logic               dir_forward;
    logic               dir_reverse;
    logic [11:0]        servo_count;
    logic signed [15:0] throttle_now;

    drive_scoreboard sb;
    drive_out_t      seen;
    bit              quiet_tail = 1'b0;
    bit              hold_req = 1'b0;

    drive_command_conditioner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .linear_cmd   (linear_cmd),
        .angular_cmd  (angular_cmd),
        .empty        (empty),
        .pop          (pop),
        .motor_duty   (motor_duty),
        .dir_forward  (dir_forward),
        .dir_reverse  (dir_reverse),
        .servo_count  (servo_count),
        .throttle_now (throttle_now)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // check every output item taken at a rising edge
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            seen = {motor_duty, dir_forward, dir_reverse, servo_count, throttle_now};
            sb.check_output(seen);
        end
    end

    // output side: random stall bursts, one long hold-off on request
    initial
    begin
        int stall;
        stall = 0;
        pop   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end
            else if (stall == 0 && !quiet_tail && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 4);
            end
            if (stall > 0)
            begin
                pop = 1'b0;
                stall--;
            end
            else
            begin
                pop = 1'b1;
            end
        end
    end

    // configuration write, only while the block is idle
    task automatic cfg_write(dcc_pkg::cfg_idx_t idx, int val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = 15'(val);
        sb.set_reg(idx, 15'(val));
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // offer one item, with an occasional gap first, until it is taken
    task automatic offer_item(dcc_pkg::op_t op, logic signed [15:0] lin,
                              logic signed [15:0] ang);
        int n;
        if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 4);
            @(negedge clk);
            push = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        push        = 1'b1;
        operation   = op;
        linear_cmd  = lin;
        angular_cmd = ang;
        do
            @(posedge clk);
        while (full);
        sb.note_item(op, lin, ang);
    endtask

    task automatic send_cmd(int lin, int ang);
        offer_item(dcc_pkg::OP_COMMAND, 16'(lin), 16'(ang));
    endtask

    task automatic send_tick();
        offer_item(dcc_pkg::OP_TICK, 16'($urandom), 16'($urandom));
    endtask

    // stop offering and wait for every due output plus the tick latency
    task automatic settle();
        @(negedge clk);
        push = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic load_config(int v0, int v1, int v2, int v3, int v4, int v5, int v6, int v7);
        cfg_write(dcc_pkg::REG_LIN_FULL_SCALE, v0);
        cfg_write(dcc_pkg::REG_ANG_FULL_SCALE, v1);
        cfg_write(dcc_pkg::REG_DEADBAND, v2);
        cfg_write(dcc_pkg::REG_ACCEL_STEP, v3);
        cfg_write(dcc_pkg::REG_TIMEOUT_TICKS, v4);
        cfg_write(dcc_pkg::REG_CENTER_ANGLE, v5);
        cfg_write(dcc_pkg::REG_MIN_ANGLE, v6);
        cfg_write(dcc_pkg::REG_MAX_ANGLE, v7);
    endtask

    function automatic int pick_reg(int hi, int usual);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return hi;
            default: return $urandom_range(1, usual);
        endcase
    endfunction

    // phase 1 all minimum, phase 2 all maximum, the rest random
    task automatic random_config(int ph);
        int lo_a;
        int hi_a;
        int mid_a;
        if (ph == 1)
        begin
            load_config(0, 0, 0, 0, 0, 0, 0, 0);
        end
        else if (ph == 2)
        begin
            load_config(32767, 32767, 32767, 32767, 255, 180, 180, 180);
        end
        else
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                lo_a  = $urandom_range(0, 180);
                hi_a  = $urandom_range(0, 180);
                mid_a = $urandom_range(0, 180);
            end
            else
            begin
                lo_a  = $urandom_range(0, 90);
                hi_a  = $urandom_range(90, 180);
                mid_a = $urandom_range(lo_a, hi_a);
            end
            load_config(pick_reg(32767, 3000), pick_reg(32767, 3000),
                        pick_reg(32767, 3000), pick_reg(32767, 6000),
                        pick_reg(255, 30), mid_a, lo_a, hi_a);
        end
    endtask

    // mostly ticks; commands near the configured full scale or fully random
    task automatic random_item();
        int ml;
        int ma;
        int lin;
        int ang;
        ml = int'(sb.regs.lin_full_scale);
        ma = int'(sb.regs.ang_full_scale);
        if ($urandom_range(0, 3) == 0)
            lin = int'($urandom_range(0, 65535)) - 32768;
        else
            lin = int'($urandom_range(0, 2 * ml + 2)) - ml - 1;
        if ($urandom_range(0, 3) == 0)
            ang = int'($urandom_range(0, 65535)) - 32768;
        else
            ang = int'($urandom_range(0, 3 * ma + 2)) - (3 * ma) / 2 - 1;
        if ($urandom_range(0, 9) < 3)
            send_cmd(lin, ang);
        else
            send_tick();
    endtask

    // main sequence
    initial
    begin
        sb          = new();
        cfg_wr_en   = 1'b0;
        cfg_index   = dcc_pkg::REG_LIN_FULL_SCALE;
        cfg_data    = '0;
        push        = 1'b0;
        operation   = dcc_pkg::OP_COMMAND;
        linear_cmd  = '0;
        angular_cmd = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults: timed out from reset, full scale both ways, ramping
        send_tick();
        send_cmd(32767, 32767);
        send_tick();
        send_tick();
        send_cmd(-32768, -32768);
        send_tick();
        send_cmd(0, 0);
        send_tick();

        // tiny full scale saturates, no deadband, one-tick ramp, never times out
        settle();
        load_config(1, 32767, 0, 32767, 255, 90, 0, 180);
        send_cmd(-32768, -1);
        send_tick();
        send_cmd(1, 32767);
        send_tick();

        // reversed angle limits, steering disabled, deadband at max, frozen ramp
        settle();
        load_config(32767, 0, 32767, 0, 0, 180, 150, 20);
        send_cmd(32767, -5000);
        send_tick();
        send_tick();

        // centre below the low limit gives a negative span; timeout after one tick
        settle();
        load_config(32767, 1000, 0, 20000, 1, 10, 40, 170);
        send_cmd(32767, -500);
        send_tick();
        send_tick();
        send_tick();
        send_cmd(-100, 500);
        send_tick();

        // random phases, long output hold-off in phase 3, no idling in the last
        for (int ph = 0; ph < 8; ph++)
        begin
            settle();
            random_config(ph);
            if (ph == 7)
                quiet_tail = 1'b1;
            for (int n = 0; n < ITEMS_PER_PH; n++)
            begin
                random_item();
                if (ph == 3 && n == 10)
                    hold_req = 1'b1;
            end
        end

        settle();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/dcc_pkg.sv
hw/rtl/dcc_front.sv
hw/rtl/dcc_job_queue.sv
hw/rtl/dcc_back.sv
hw/rtl/drive_command_conditioner.sv
test/drive_command_conditioner_tb.sv
